### hdl/rrme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrme_pkg
// Shared types and constants of the relay rule matrix evaluator.
// ----------------------------------------------------------------------------
package rrme_pkg;

   localparam int MAX_RULES = 64;
   localparam int IDX_W     = $clog2(MAX_RULES);
   localparam int ADDR_W    = IDX_W + 2;
   localparam int CNT_W     = 7;
   localparam int VEC_W     = 128;

   localparam logic [2:0] CMD_LOAD   = 3'd0;
   localparam logic [2:0] CMD_SET    = 3'd1;
   localparam logic [2:0] CMD_CLEAR  = 3'd2;
   localparam logic [2:0] CMD_APPLY  = 3'd3;
   localparam logic [2:0] CMD_RECALC = 3'd4;

   localparam logic [2:0] REG_PREP_CNT  = 3'd0;
   localparam logic [2:0] REG_MAIN_CNT  = 3'd1;
   localparam logic [2:0] REG_STAT_CNT  = 3'd2;
   localparam logic [2:0] REG_DYN_CNT   = 3'd3;
   localparam logic [2:0] REG_CSENSE_LO = 3'd4;
   localparam logic [2:0] REG_CSENSE_HI = 3'd5;
   localparam logic [2:0] REG_DSENSE_LO = 3'd6;
   localparam logic [2:0] REG_DSENSE_HI = 3'd7;

   localparam logic [1:0] GRP_PREP = 2'd0;
   localparam logic [1:0] GRP_MAIN = 2'd1;
   localparam logic [1:0] GRP_STAT = 2'd2;
   localparam logic [1:0] GRP_DYN  = 2'd3;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_DYN  = 2'd1;
   localparam logic [1:0] KIND_FULL = 2'd2;

   localparam int REQ_W = 3 + 2 + IDX_W + 7 + 4 * 64;
   localparam int REQ_BYTES_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_W = 2 + 4 * 64 + 2;
   localparam int RSP_BYTES_W = ((RSP_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_SCAN, ST_LAST, ST_OUT
   } state_type;

   // one rule memory write
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [VEC_W-1:0]  mask;
      logic [VEC_W-1:0]  result;
   } rule_wr_type;

   // clamp a group count to the table depth
   function automatic logic [IDX_W:0] clamp_count(input logic [CNT_W-1:0] n);
      if (n > CNT_W'(MAX_RULES)) return (IDX_W+1)'(MAX_RULES);
      return (IDX_W+1)'(n);
   endfunction

endpackage

### hdl/rrme_rule_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrme_rule_ram
// Rule store: one mask and one result word per entry, registered read.
// ----------------------------------------------------------------------------
module rrme_rule_ram (
   input  logic                         clock,
   input  rrme_pkg::rule_wr_type        wr,
   input  logic [rrme_pkg::ADDR_W-1:0]  rd_addr,
   output logic [rrme_pkg::VEC_W-1:0]   rd_mask,
   output logic [rrme_pkg::VEC_W-1:0]   rd_result
);
   import rrme_pkg::*;

   logic [2*VEC_W-1:0] mem [4*MAX_RULES];
   logic [2*VEC_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= {wr.result, wr.mask};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_mask   = rd_ff[VEC_W-1:0];
   assign rd_result = rd_ff[2*VEC_W-1:VEC_W];

endmodule

### hdl/relay_rule_matrix_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_rule_matrix_evaluator_unit
// Relay status vector with four rule tables and a sequenced evaluator.
// ----------------------------------------------------------------------------
// Usage:
//  req_ carries one command per beat (load rule, set/clear bit, apply
//  masks, recalculate). Every command returns exactly one rsp_ beat with
//  the done kind, the drive vector, the sensitivity vector and the
//  pending kind. csr_ writes the counts and sense masks; the user must do so
//  only while idle, which the block itself does not enforce.
//  Throughput: one command at a time. Load, set, clear and apply present
//  their response in the cycle after accept. A recalculation scans the rule
//  memory one entry a cycle through its single read port, all four groups
//  when full, only the dynamic one otherwise (counts clamped to 64).
//  Reset: a clearing pass writes zero to all 256 rule entries, one per
//  cycle, before the first command is accepted; full recalculation is
//  pending after reset.
//  Stall: a response holds in the output register until rsp_tready; the
//  next command is taken only after the response is taken.
// ----------------------------------------------------------------------------
module relay_rule_matrix_evaluator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command, rule_group, rule_index, bit_number, mask_lo, mask_hi,
   // value_lo, value_hi
   input  logic [rrme_pkg::REQ_BYTES_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // done_kind, drive_lo, drive_hi, sense_lo, sense_hi, pending_kind
   output logic [rrme_pkg::RSP_BYTES_W-1:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import rrme_pkg::*;

   logic [2:0]       f_cmd;
   logic [1:0]       f_grp;
   logic [IDX_W-1:0] f_idx;
   logic [6:0]       f_bit;
   logic [VEC_W-1:0] f_mask, f_value;

   assign f_cmd   = req_tdata[2:0];
   assign f_grp   = req_tdata[4:3];
   assign f_idx   = req_tdata[5 +: IDX_W];
   assign f_bit   = req_tdata[5+IDX_W +: 7];
   assign f_mask  = req_tdata[12+IDX_W +: VEC_W];
   assign f_value = req_tdata[12+IDX_W+VEC_W +: VEC_W];

   logic [CNT_W-1:0] cnt_ff [4];
   logic [VEC_W-1:0] csense_ff, dsense_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < 4; g++) cnt_ff[g] <= '0;
         csense_ff <= '0;
         dsense_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_PREP_CNT:  cnt_ff[0] <= csr_wdata[CNT_W-1:0];
            REG_MAIN_CNT:  cnt_ff[1] <= csr_wdata[CNT_W-1:0];
            REG_STAT_CNT:  cnt_ff[2] <= csr_wdata[CNT_W-1:0];
            REG_DYN_CNT:   cnt_ff[3] <= csr_wdata[CNT_W-1:0];
            REG_CSENSE_LO: csense_ff[63:0]   <= csr_wdata;
            REG_CSENSE_HI: csense_ff[127:64] <= csr_wdata;
            REG_DSENSE_LO: dsense_ff[63:0]   <= csr_wdata;
            REG_DSENSE_HI: dsense_ff[127:64] <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type        state_ff, state_in;
   logic [VEC_W-1:0] status_ff, status_in;
   logic [VEC_W-1:0] sense_ff, sense_in;
   logic [VEC_W-1:0] ssense_ff, ssense_in;
   logic [VEC_W-1:0] work_ff, work_in;
   logic [VEC_W-1:0] acc_ff, acc_in;
   logic [VEC_W-1:0] drive_ff, drive_in;
   logic             fullp_ff, fullp_in, dynp_ff, dynp_in;
   logic [1:0]       done_ff, done_in;
   logic [1:0]       grp_ff, grp_in;
   logic [IDX_W:0]   pos_ff, pos_in;   // next entry to issue
   logic             rv_ff, rv_in;     // read data valid this cycle
   logic [ADDR_W:0]  clr_ff, clr_in;

   rule_wr_type      wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [VEC_W-1:0] rd_mask, rd_result;

   rrme_rule_ram u_ram (
      .clock     (clock),
      .wr        (wr),
      .rd_addr   (rd_addr),
      .rd_mask   (rd_mask),
      .rd_result (rd_result)
   );

   logic [IDX_W:0]   grp_n;
   logic             fires;
   logic [VEC_W-1:0] acc_hit;
   logic [VEC_W-1:0] bit_onehot, new_status, diff;

   assign grp_n      = clamp_count(cnt_ff[grp_ff]);
   assign fires      = ((rd_mask & ~work_ff) == '0);
   assign acc_hit    = (rv_ff && fires) ? (acc_ff | rd_result) : acc_ff;
   assign bit_onehot = VEC_W'(1) << f_bit;
   assign new_status = (status_ff & f_value) | f_mask;
   assign diff       = status_ff ^ new_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         status_ff <= '0;
         sense_ff  <= '0;
         ssense_ff <= '0;
         fullp_ff  <= 1'b1;
         dynp_ff   <= 1'b0;
         clr_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         sense_ff  <= sense_in;
         ssense_ff <= ssense_in;
         fullp_ff  <= fullp_in;
         dynp_ff   <= dynp_in;
         clr_ff    <= clr_in;
         rv_ff     <= rv_in;
      end
      work_ff  <= work_in;
      acc_ff   <= acc_in;
      drive_ff <= drive_in;
      done_ff  <= done_in;
      grp_ff   <= grp_in;
      pos_ff   <= pos_in;
   end

   // Scan: issue reads for pos, consume data in the following cycle. The last
   // read lands as pos reaches the count; ST_LAST then switches group or ends the scan.
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      sense_in  = sense_ff;
      ssense_in = ssense_ff;
      fullp_in  = fullp_ff;
      dynp_in   = dynp_ff;
      work_in   = work_ff;
      acc_in    = acc_ff;
      drive_in  = drive_ff;
      done_in   = done_ff;
      grp_in    = grp_ff;
      pos_in    = pos_ff;
      clr_in    = clr_ff;
      rv_in     = 1'b0;
      wr        = '0;
      rd_addr   = {grp_ff, pos_ff[IDX_W-1:0]};
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = clr_ff[ADDR_W-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (ADDR_W+1)'(4*MAX_RULES-1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               done_in  = KIND_NONE;
               drive_in = '0;
               state_in = ST_OUT;
               case (f_cmd)
                  CMD_LOAD: begin
                     if ((IDX_W+1)'(f_idx) < clamp_count(cnt_ff[f_grp])) begin
                        wr.en     = 1'b1;
                        wr.addr   = {f_grp, f_idx};
                        wr.mask   = f_mask;
                        wr.result = f_value;
                     end
                  end
                  CMD_SET: begin
                     status_in = status_ff | bit_onehot;
                     if (!status_ff[f_bit]) fullp_in = 1'b1;
                  end
                  CMD_CLEAR: begin
                     status_in = status_ff & ~bit_onehot;
                     if (status_ff[f_bit]) fullp_in = 1'b1;
                  end
                  CMD_APPLY: begin
                     status_in = new_status;
                     if ((diff & sense_ff) != '0) fullp_in = 1'b1;
                     else if ((diff & dsense_ff) != '0) dynp_in = 1'b1;
                  end
                  CMD_RECALC: begin
                     work_in  = status_ff;
                     pos_in   = '0;
                     state_in = ST_SCAN;
                     if (fullp_ff) begin
                        grp_in  = GRP_PREP;
                        acc_in  = '0;
                        done_in = KIND_FULL;
                     end else begin
                        grp_in  = GRP_DYN;
                        acc_in  = csense_ff | ssense_ff;
                        done_in = KIND_DYN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            acc_in = acc_hit;
            if (pos_ff < grp_n) begin
               rv_in  = 1'b1;
               pos_in = pos_ff + 1'b1;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // acc_ff already holds the whole group's OR
            pos_in   = '0;
            state_in = ST_SCAN;
            case (grp_ff)
               GRP_PREP: begin
                  work_in = work_ff | acc_ff;
                  acc_in  = '0;
                  grp_in  = GRP_MAIN;
               end
               GRP_MAIN: begin
                  drive_in = acc_ff;
                  acc_in   = '0;
                  grp_in   = GRP_STAT;
               end
               GRP_STAT: begin
                  ssense_in = acc_ff;
                  acc_in    = csense_ff | acc_ff;
                  grp_in    = GRP_DYN;
               end
               default: begin
                  sense_in = acc_ff;
                  fullp_in = 1'b0;
                  dynp_in  = 1'b0;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = RSP_BYTES_W'({
      (fullp_ff ? KIND_FULL : (dynp_ff ? KIND_DYN : KIND_NONE)),
      sense_ff, drive_ff, done_ff});

`ifndef SYNTHESIS
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_LAST) |-> !wr.en)
      else $error("rule write during scan");
   a_clear_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST && grp_ff == GRP_DYN) |=> (!fullp_ff && !dynp_ff))
      else $error("pending flags not cleared");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response dropped under stall");
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second command taken before response");
`endif

endmodule
